// File: rtl/core/caf_pkg.sv
package caf_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned OpW   = 5;
  localparam int unsigned ShW   = 5;

  // Operation select codes
  typedef enum logic [OpW-1:0] {
    OP_ADD = 5'd0,
    OP_ADC = 5'd1,
    OP_AND = 5'd2,
    OP_BIC = 5'd3,
    OP_EOR = 5'd4,
    OP_MOV = 5'd5,
    OP_MVN = 5'd6,
    OP_ORR = 5'd7,
    OP_RSB = 5'd8,
    OP_RSC = 5'd9,
    OP_SBC = 5'd10,
    OP_SUB = 5'd11,
    OP_LSL = 5'd12,
    OP_LSR = 5'd13,
    OP_ASR = 5'd14,
    OP_ROR = 5'd15,
    OP_MUL = 5'd16
  } op_e;

  // Condition flags
  typedef struct packed {
    logic n;
    logic z;
    logic c;
    logic v;
  } nzcv_t;

endpackage

// File: rtl/core/caf_req_if.sv
interface caf_req_if
  import caf_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [OpW-1:0]    req_type;
  logic [DataW-1:0]  operand_a;
  logic [DataW-1:0]  operand_b;
  logic              update_flags;

  modport source (output valid, req_type, operand_a, operand_b, update_flags, input ready);
  modport sink   (input valid, req_type, operand_a, operand_b, update_flags, output ready);
endinterface

// File: rtl/core/caf_rsp_if.sv
interface caf_rsp_if
  import caf_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [DataW-1:0]  value;
  logic              neg_flag;
  logic              zero_flag;
  logic              carry_flag;
  logic              ovf_flag;

  modport source (output valid, value, neg_flag, zero_flag, carry_flag, ovf_flag, input ready);
  modport sink   (input valid, value, neg_flag, zero_flag, carry_flag, ovf_flag, output ready);
endinterface

// File: rtl/core/caf_exec.sv
module caf_exec
  import caf_pkg::*;
(
  input  logic [OpW-1:0]   op_i,
  input  logic [DataW-1:0] operand_a_i,
  input  logic [DataW-1:0] operand_b_i,
  input  logic             upd_i,
  input  nzcv_t            flags_i,
  output logic [DataW-1:0] value_o,
  output nzcv_t            flags_o
);

  logic [ShW-1:0]   amt;
  logic             cin;
  logic [DataW-1:0] add_x, add_y;
  logic             add_cin;
  logic [DataW:0]   add_sum;
  logic [DataW-1:0] add_res;
  logic             add_v;
  logic [DataW:0]   lsl_w, lsr_w, asr_w;
  logic [2*DataW-1:0] ror_w;
  logic [DataW-1:0] mul_w;
  logic [DataW-1:0] res;
  logic             c_new, v_new, known;

  assign amt = operand_b_i[ShW-1:0];
  assign cin = flags_i.c;

  // Operand steering for the shared adder: subtraction inverts one side
  always_comb begin
    add_x   = operand_a_i;
    add_y   = operand_b_i;
    add_cin = 1'b0;
    case (op_i)
      OP_ADC: add_cin = cin;
      OP_RSB: begin add_x = operand_b_i; add_y = ~operand_a_i; add_cin = 1'b1; end
      OP_RSC: begin add_x = operand_b_i; add_y = ~operand_a_i; add_cin = cin;  end
      OP_SBC: begin add_y = ~operand_b_i; add_cin = cin;  end
      OP_SUB: begin add_y = ~operand_b_i; add_cin = 1'b1; end
      default: ;
    endcase
  end

  assign add_sum = {1'b0, add_x} + {1'b0, add_y} + {{DataW{1'b0}}, add_cin};
  assign add_res = add_sum[DataW-1:0];
  assign add_v   = (add_x[DataW-1] ^ add_res[DataW-1]) & (add_y[DataW-1] ^ add_res[DataW-1]);

  // Shifters; the extra bit catches the last bit shifted out
  assign lsl_w = {1'b0, operand_a_i} << amt;
  assign lsr_w = {operand_a_i, 1'b0} >> amt;
  assign asr_w = $unsigned($signed({operand_a_i, 1'b0}) >>> amt);
  assign ror_w = {operand_a_i, operand_a_i} >> amt;

  // Only the low word of the product is kept
  assign mul_w = operand_a_i * operand_b_i;

  // Result and carry/overflow select
  always_comb begin
    res   = '0;
    c_new = flags_i.c;
    v_new = flags_i.v;
    known = 1'b1;
    case (op_i)
      OP_ADD, OP_ADC, OP_RSB, OP_RSC, OP_SBC, OP_SUB: begin
        res   = add_res;
        c_new = add_sum[DataW];
        v_new = add_v;
      end
      OP_AND: res = operand_a_i & operand_b_i;
      OP_BIC: res = operand_a_i & ~operand_b_i;
      OP_EOR: res = operand_a_i ^ operand_b_i;
      OP_MOV: res = operand_b_i;
      OP_MVN: res = ~operand_b_i;
      OP_ORR: res = operand_a_i | operand_b_i;
      OP_LSL: begin
        res = lsl_w[DataW-1:0];
        if (amt != '0) c_new = lsl_w[DataW];
      end
      OP_LSR: begin
        // zero amount encodes a shift by 32
        if (amt == '0) begin
          res   = '0;
          c_new = operand_a_i[DataW-1];
        end else begin
          res   = lsr_w[DataW:1];
          c_new = lsr_w[0];
        end
      end
      OP_ASR: begin
        if (amt == '0) begin
          res   = {DataW{operand_a_i[DataW-1]}};
          c_new = operand_a_i[DataW-1];
        end else begin
          res   = asr_w[DataW:1];
          c_new = asr_w[0];
        end
      end
      OP_ROR: begin
        // zero amount encodes rotate right through carry
        if (amt == '0) begin
          res   = {cin, operand_a_i[DataW-1:1]};
          c_new = operand_a_i[0];
        end else begin
          res   = ror_w[DataW-1:0];
          c_new = ror_w[DataW-1];
        end
      end
      OP_MUL: res = mul_w;
      default: known = 1'b0;
    endcase
  end

  assign value_o = res;

  // Flag write-back
  always_comb begin
    flags_o = flags_i;
    if (known && upd_i) begin
      flags_o.n = res[DataW-1];
      flags_o.z = (res == '0);
      flags_o.c = c_new;
      flags_o.v = v_new;
    end
  end

endmodule

// File: rtl/core/cpu_alu_with_flags.sv
// 32-bit ALU with N, Z, C, V condition flags. Each request beat carries an
// operation select, two operands and an update_flags bit; each request gives
// exactly one response beat with the result and the flags held after it.
// Throughput is one beat per cycle while responses are taken. A request
// accepted into the input register moves on into the result register,
// which drives the response; response back-pressure holds both registers.
// The flag register is written as an operation moves into the result
// register, so the next operation in the input register sees it at once.
// Reset clears the flags. Unused select codes give zero and keep flags.
module cpu_alu_with_flags
  import caf_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  caf_req_if.sink   req_i,
  caf_rsp_if.source rsp_o
);

  logic             in_vld_q;
  logic [OpW-1:0]   op_q;
  logic [DataW-1:0] a_q, b_q;
  logic             upd_q;
  logic             out_vld_q;
  logic [DataW-1:0] value_q;
  nzcv_t            flags_q, flags_d, out_flags_q;
  logic [DataW-1:0] value_d;
  logic             adv;

  // Move the held beat on when the result register is free or draining
  assign adv         = in_vld_q && (!out_vld_q || rsp_o.ready);
  assign req_i.ready = !in_vld_q || adv;

  caf_exec u_exec (
    .op_i        (op_q),
    .operand_a_i (a_q),
    .operand_b_i (b_q),
    .upd_i       (upd_q),
    .flags_i     (flags_q),
    .value_o     (value_d),
    .flags_o     (flags_d)
  );

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      flags_q   <= '0;
    end else begin
      if (req_i.ready) in_vld_q <= req_i.valid;
      if (adv) begin
        out_vld_q <= 1'b1;
        flags_q   <= flags_d;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      op_q  <= req_i.req_type;
      a_q   <= req_i.operand_a;
      b_q   <= req_i.operand_b;
      upd_q <= req_i.update_flags;
    end
    if (adv) begin
      value_q     <= value_d;
      out_flags_q <= flags_d;
    end
  end

  assign rsp_o.valid      = out_vld_q;
  assign rsp_o.value      = value_q;
  assign rsp_o.neg_flag   = out_flags_q.n;
  assign rsp_o.zero_flag  = out_flags_q.z;
  assign rsp_o.carry_flag = out_flags_q.c;
  assign rsp_o.ovf_flag   = out_flags_q.v;

endmodule
